>>> rtl/cpas_pkg.sv
package cpas_pkg;

  // Capacity of the sorting chain
  localparam int MaxItems = 32;
  localparam int IdxW     = $clog2(MaxItems);
  localparam int CntW     = $clog2(MaxItems + 1);

  typedef logic signed [31:0] value_t;

  typedef struct packed {
    value_t value;
    logic   last;
  } in_item_t;

  typedef struct packed {
    value_t      first_value;
    value_t      second_value;
    logic [31:0] min_gap;
    logic        pair_valid;
    logic        overflowed;
    logic        end_of_run;
  } out_item_t;

  // Per-cycle command shared by every cell of the chain
  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SINGLE,
    ST_MIN,
    ST_EMIT
  } state_e;

endpackage

>>> rtl/cpas_cell.sv
module cpas_cell (
  input  logic                clk_i,
  input  cpas_pkg::cell_ctl_t ctl_i,
  input  cpas_pkg::value_t    new_value_i,
  input  logic                occupied_i,
  input  cpas_pkg::value_t    left_value_i,
  input  logic                left_gt_i,
  input  cpas_pkg::value_t    right_value_i,
  output cpas_pkg::value_t    value_o,
  output logic                gt_o
);
  import cpas_pkg::*;

  value_t value_q;
  value_t value_d;

  // Cell yields its slot when empty or holding a larger value
  assign gt_o    = !occupied_i || (new_value_i < value_q);
  assign value_o = value_q;

  // Insert: shift up from the left or take the new value; rotate: pull from the right
  always_comb begin
    value_d = value_q;
    if (ctl_i.insert && gt_o) begin
      value_d = left_gt_i ? left_value_i : new_value_i;
    end else if (ctl_i.rotate) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

>>> rtl/closest_pairs_after_sort.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid_i/stall_o  | in_item_i  (value, last)
// out     | output    | out_valid_o/stall_i | out_item_o (pair, gap, flags)
//
// Loading accepts one item per cycle; values are insertion-sorted in place by
// the cell chain as they arrive. After the last item of a set of two or more,
// the chain rotates once to find the minimum gap, then rotates again to emit
// the matching pairs. Reset clears the control state; cell contents are
// don't-care until loaded. An output stall holds only the emit scan and the
// empty-set item; a finished result waits in the output register while
// loading of the next set goes on.
module closest_pairs_after_sort (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cpas_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cpas_pkg::out_item_t out_item_o
);
  import cpas_pkg::*;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              dropped_q, dropped_d;
  logic [IdxW-1:0]   step_q, step_d;
  logic [31:0]       best_q, best_d;
  logic [IdxW-1:0]   mcnt_q, mcnt_d;
  logic [IdxW-1:0]   emitted_q, emitted_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  cell_ctl_t         ctl;
  value_t            cell_value [MaxItems];
  logic              cell_gt    [MaxItems];

  logic              in_acc;
  logic              out_free;
  logic              pair_ok;
  logic              match;
  logic [32:0]       diff;
  logic [31:0]       gap;

  // Sorting chain: smallest value in cell 0
  for (genvar i = 0; i < MaxItems; i++) begin : g_cell
    cpas_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .new_value_i  (in_item_i.value),
      .occupied_i   (CntW'(i) < count_q),
      .left_value_i ((i == 0) ? cell_value[0] : cell_value[(i + MaxItems - 1) % MaxItems]),
      .left_gt_i    ((i == 0) ? 1'b0 : cell_gt[(i + MaxItems - 1) % MaxItems]),
      .right_value_i(cell_value[(i + 1) % MaxItems]),
      .value_o      (cell_value[i]),
      .gt_o         (cell_gt[i])
    );
  end

  // Gap of the pair at the head of the chain; exact as the pair is sorted
  assign diff    = {cell_value[1][31], cell_value[1]} - {cell_value[0][31], cell_value[0]};
  assign gap     = diff[31:0];
  assign pair_ok = ({1'b0, step_q} + CntW'(1)) < count_q;
  assign match   = pair_ok && (gap == best_q);

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer: load, min-gap pass, emit pass, or one empty item for a set of fewer than two
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    step_d      = step_q;
    best_d      = best_q;
    mcnt_d      = mcnt_q;
    emitted_d   = emitted_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctl         = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (count_q < CntW'(MaxItems)) begin
            ctl.insert = 1'b1;
            count_d    = count_q + CntW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (in_item_i.last) begin
            step_d  = '0;
            state_d = (count_d < CntW'(2)) ? ST_SINGLE : ST_MIN;
          end
        end
      end
      ST_SINGLE: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_item_d            = '0;
          out_item_d.overflowed = dropped_q;
          out_item_d.end_of_run = 1'b1;
          count_d               = '0;
          dropped_d             = 1'b0;
          state_d               = ST_LOAD;
        end
      end
      ST_MIN: begin
        ctl.rotate = 1'b1;
        step_d     = step_q + IdxW'(1);
        if (pair_ok) begin
          if ((step_q == '0) || (gap < best_q)) begin
            best_d = gap;
            mcnt_d = IdxW'(1);
          end else if (gap == best_q) begin
            mcnt_d = mcnt_q + IdxW'(1);
          end
        end
        if (step_q == IdxW'(MaxItems - 1)) begin
          step_d    = '0;
          emitted_d = '0;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!match || out_free) begin
          ctl.rotate = 1'b1;
          step_d     = step_q + IdxW'(1);
        end
        if (match && out_free) begin
          out_valid_d             = 1'b1;
          out_item_d.first_value  = cell_value[0];
          out_item_d.second_value = cell_value[1];
          out_item_d.min_gap      = best_q;
          out_item_d.pair_valid   = 1'b1;
          out_item_d.overflowed   = dropped_q;
          out_item_d.end_of_run   = (emitted_q == (mcnt_q - IdxW'(1)));
          emitted_d               = emitted_q + IdxW'(1);
          if (emitted_q == (mcnt_q - IdxW'(1))) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      step_q      <= '0;
      mcnt_q      <= '0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      step_q      <= step_d;
      mcnt_q      <= mcnt_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> rtl/cpas_chk.sv
module cpas_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_i,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input cpas_pkg::out_item_t out_item_i
);
  import cpas_pkg::*;

  logic [31:0] pair_diff;

  assign pair_diff = out_item_i.second_value - out_item_i.first_value;

  // Stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled output item changed");

  // An item without a pair closes its set
  a_nopair_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.pair_valid |-> out_item_i.end_of_run)
    else $error("item without a pair does not close the set");

  // Each pair's values come out in ascending order
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.pair_valid |->
      out_item_i.second_value >= out_item_i.first_value)
    else $error("pair not in ascending order");

  // Each pair's gap is the reported minimum
  a_pair_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.pair_valid |-> pair_diff == out_item_i.min_gap)
    else $error("pair gap differs from minimum");

  // A set with no pair never yields an empty item before input was taken
  a_input_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) && !out_item_i.pair_valid |-> $past(in_stall_i))
    else $error("empty-set item without a loaded set");

endmodule

bind closest_pairs_after_sort cpas_chk u_cpas_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_i (in_stall_o),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_i (out_item_o)
);
